// ===== rtl/sliding_window_min_max_top_macros.svh =====
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define SWMM_ASSERT_SAME(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define SWMM_ASSERT_NEXT(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/swmm_pkg.sv =====
`default_nettype none

package swmm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int CFG_W      = 7;
	localparam int SAMPLE_W   = 18;
	localparam int IDX_W      = 16;
	localparam int VAL_W      = 8;
	localparam int ENTRY_W    = VAL_W + 1;

	localparam logic [CFG_W-1:0]    WINDOW_RESET = CFG_W'(8);
	localparam logic [SAMPLE_W-2:0] LIMIT_RAW    = (SAMPLE_W-1)'(38400);
	localparam logic [VAL_W-1:0]    NONE_MIN     = VAL_W'(150);

	typedef enum logic [1:0] {
		KIND_STATS,
		KIND_RANGE,
		KIND_TERM,
		KIND_IGNORED
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t                       kind;
		logic [IDX_W-1:0]            sample_index;
		logic signed [SAMPLE_W-1:0]  echo_value;
		logic [VAL_W-1:0]            window_min;
		logic [VAL_W-1:0]            window_max;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/swmm_ram.sv =====
`default_nettype none

module swmm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/swmm_core.sv =====
`default_nettype none

module swmm_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [swmm_pkg::CFG_W-1:0]             window_size,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [swmm_pkg::SAMPLE_W-1:0]   in_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output swmm_pkg::result_t                           out_res
);

	import swmm_pkg::*;

	state_t                 state_q, state_d;
	logic                   stopped_q;
	logic [IDX_W-1:0]       count_q;
	logic [ADDR_W-1:0]      slot_q;
	logic [MAX_WINDOW-1:0]  written_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       win_s1;
	logic [VAL_W-1:0]       min_q, max_q;
	kind_t                  kind_q;
	logic signed [SAMPLE_W-1:0] echo_q;
	logic                   rd_valid_s1;
	logic                   flag_s1;
	logic [ENTRY_W-1:0]     rd_data;

	logic                   accept;
	logic                   neg;
	logic                   over;
	logic                   store;
	logic [ENTRY_W-1:0]     entry;
	logic [CNT_W-1:0]       win_eff;
	logic                   out_free;
	kind_t                  kind_d;

	assign accept   = in_valid && in_ready;
	assign neg      = in_sample[SAMPLE_W-1];
	assign over     = in_sample[SAMPLE_W-2:0] >= LIMIT_RAW;
	assign store    = accept && !stopped_q && !neg;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if (!over && (in_sample != '0)) begin
			entry = {1'b1, in_sample[VAL_W+7:8]};
		end else begin
			entry = '0;
		end
	end

	always_comb begin
		if (window_size == '0) begin
			win_eff = CNT_W'(1);
		end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(window_size);
		end
	end

	always_comb begin
		if (stopped_q) begin
			kind_d = KIND_IGNORED;
		end else if (neg) begin
			kind_d = KIND_TERM;
		end else if (over) begin
			kind_d = KIND_RANGE;
		end else begin
			kind_d = KIND_STATS;
		end
	end

	swmm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_WINDOW)
	) u_window_ram (
		.clk   (clk),
		.we    (store),
		.waddr (slot_q),
		.wdata (entry),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (kind_d == KIND_STATS) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (k_q == win_s1 - CNT_W'(1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q   <= 1'b0;
			count_q     <= '0;
			slot_q      <= '0;
			written_q   <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				count_q <= count_q + IDX_W'(1);
				if (!stopped_q && neg) begin
					stopped_q <= 1'b1;
				end
			end
			if (store) begin
				written_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_q + ADDR_W'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		flag_s1 <= written_q[pos_q];
		if (accept) begin
			kind_q <= kind_d;
			echo_q <= in_sample;
			win_s1 <= win_eff;
			pos_q  <= slot_q;
			k_q    <= '0;
			min_q  <= (kind_d == KIND_STATS) ? NONE_MIN : '0;
			max_q  <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				k_q   <= k_q + CNT_W'(1);
				pos_q <= (pos_q == '0) ? ADDR_W'(MAX_WINDOW - 1) : pos_q - ADDR_W'(1);
			end
			if (rd_valid_s1 && flag_s1 && rd_data[VAL_W]) begin
				if (rd_data[VAL_W-1:0] < min_q) begin
					min_q <= rd_data[VAL_W-1:0];
				end
				if (rd_data[VAL_W-1:0] > max_q) begin
					max_q <= rd_data[VAL_W-1:0];
				end
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_res.kind         <= kind_q;
			out_res.sample_index <= count_q;
			out_res.echo_value   <= echo_q;
			out_res.window_min   <= min_q;
			out_res.window_max   <= max_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max_top.sv =====
// Channel   Direction  Signals                           Content
// s_axis    in         tvalid tready tdata[23:0]         sample
// m_axis    out        tvalid tready tdata[55:0] tuser   kind, index, echo, min, max
// cfg       in         valid ready data[6:0]             window_size
//
// A stats row scans the last w window entries before it reaches the output register,
// where w is window_size with zero read as one and values above 64 read as 64; the scan
// reads one window entry a cycle from the single RAM read port.
// Every other kind of item goes to the output register without a scan.
// Reset clears the window valid marks, the ring position, the count and the stop flag.
// A waiting result does not block acceptance of the next sample.
`default_nettype none

`include "sliding_window_min_max_top_macros.svh"

module sliding_window_min_max_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // sample [17:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // sample_index, echo_value, window_min, window_max
	output logic [1:0]       m_axis_tuser,   // kind
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data        // window_size
);

	import swmm_pkg::*;

	logic [CFG_W-1:0] window_size_q;
	result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= cfg_data;
		end
	end

	swmm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_size_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata[SAMPLE_W-1:0]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	assign m_axis_tuser = res.kind;
	assign m_axis_tdata = {6'd0, res.window_max, res.window_min, res.echo_value,
		res.sample_index};

	`SWMM_ASSERT_SAME(a_other_kind_no_stats,
		m_axis_tvalid && (res.kind != KIND_STATS),
		(res.window_min == '0) && (res.window_max == '0))

	`SWMM_ASSERT_SAME(a_min_not_above_max,
		m_axis_tvalid && (res.kind == KIND_STATS) && (res.window_min != NONE_MIN),
		res.window_min <= res.window_max)

	`SWMM_ASSERT_NEXT(a_one_item_at_a_time,
		s_axis_tvalid && s_axis_tready,
		!s_axis_tready)

endmodule

`default_nettype wire

// ===== bench/tb_sliding_window_min_max_top.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_min_max_top;
	import swmm_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 2 * MAX_WINDOW + 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	sliding_window_min_max_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Mirror of the block state, updated as each sample transaction is accepted.
	logic [ENTRY_W-1:0] ring_entries [MAX_WINDOW];
	int                 ring_slot = 0;
	logic [IDX_W-1:0]   samples_seen = '0;
	logic               halted = 1'b0;
	logic [CFG_W-1:0]   span_setting = WINDOW_RESET;

	result_t pending_rows[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      stall_left = 0;
	bit      idle_on = 1'b1;

	initial begin
		foreach (ring_entries[i])
			ring_entries[i] = '0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic track_window(input logic signed [SAMPLE_W-1:0] value, output result_t row);
		int span;
		int pos;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		samples_seen++;
		row.kind = KIND_STATS;
		row.sample_index = samples_seen;
		row.echo_value = value;
		row.window_min = '0;
		row.window_max = '0;
		if (halted) begin
			row.kind = KIND_IGNORED;
		end else if (value < 0) begin
			row.kind = KIND_TERM;
			halted = 1'b1;
		end else if (int'(value) >= int'(LIMIT_RAW)) begin
			row.kind = KIND_RANGE;
			ring_entries[ring_slot] = '0;
			ring_slot = (ring_slot + 1) % MAX_WINDOW;
		end else begin
			ring_entries[ring_slot] = (value != 0) ? {1'b1, value[VAL_W+7:8]} : '0;
			span = (span_setting == 0) ? 1 : int'(span_setting);
			if (span > MAX_WINDOW)
				span = MAX_WINDOW;
			lo = NONE_MIN;
			hi = '0;
			pos = ring_slot;
			for (int k = 0; k < span; k++) begin
				if (ring_entries[pos][VAL_W]) begin
					if (ring_entries[pos][VAL_W-1:0] < lo)
						lo = ring_entries[pos][VAL_W-1:0];
					if (ring_entries[pos][VAL_W-1:0] > hi)
						hi = ring_entries[pos][VAL_W-1:0];
				end
				pos = (pos == 0) ? MAX_WINDOW - 1 : pos - 1;
			end
			row.window_min = lo;
			row.window_max = hi;
			ring_slot = (ring_slot + 1) % MAX_WINDOW;
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		result_t row;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(24 - SAMPLE_W){1'b0}}, value};
		do @(posedge clk); while (!s_axis_tready);
		track_window(value, row);
		pending_rows.push_back(row);
	endtask

	task automatic wait_rows_drained();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] value);
		wait_rows_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		span_setting = value;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		else if (pick < 15)
			return SAMPLE_W'($urandom_range(int'(LIMIT_RAW), 131071));
		else if (pick < 20)
			return SAMPLE_W'($urandom_range(int'(LIMIT_RAW) - 300, int'(LIMIT_RAW) - 1));
		else if (pick < 25)
			return SAMPLE_W'($urandom_range(1, 511));
		else
			return SAMPLE_W'($urandom_range(1, int'(LIMIT_RAW) - 1));
	endfunction

	task automatic check_row();
		result_t want;
		if (pending_rows.size() == 0) begin
			report_mismatch("row with none expected, index", 32'(m_axis_tdata[15:0]), 0);
		end else begin
			want = pending_rows.pop_front();
			if (m_axis_tuser !== want.kind)
				report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
			if (m_axis_tdata[15:0] !== want.sample_index)
				report_mismatch("sample_index", 32'(m_axis_tdata[15:0]), 32'(want.sample_index));
			if (m_axis_tdata[33:16] !== want.echo_value)
				report_mismatch("echo_value", 32'(m_axis_tdata[33:16]),
					32'(unsigned'(want.echo_value)));
			if (m_axis_tdata[41:34] !== want.window_min)
				report_mismatch("window_min", 32'(m_axis_tdata[41:34]), 32'(want.window_min));
			if (m_axis_tdata[49:42] !== want.window_max)
				report_mismatch("window_max", 32'(m_axis_tdata[49:42]), 32'(want.window_max));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_row();
			if (!idle_on) begin
				stall_left = 0;
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic test_field_extremes();
		int values[] = '{0, 1, 255, 256, 257, 38399, 38400, 38401, 131071, 12800,
			25600, 87381, 43690, 5461, 100, 38399};
		foreach (values[i])
			send_sample(SAMPLE_W'(values[i]));
		wait_rows_drained();
	endtask

	task automatic test_window_sizes();
		// The widest window first, while most ring slots have never been written.
		write_window(7'd64);
		repeat (10) send_sample(random_sample());
		write_window(7'd0);
		repeat (5) send_sample(random_sample());
		write_window(7'd1);
		repeat (4) send_sample(random_sample());
		write_window(7'd127);
		repeat (MAX_WINDOW + 2) send_sample(random_sample());
		write_window(7'd2);
		repeat (5) send_sample(random_sample());
		wait_rows_drained();
	endtask

	task automatic test_random_phases();
		int pick;
		for (int phase = 0; phase < 14; phase++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				write_window(7'd0);
			else if (pick == 1)
				write_window(7'd127);
			else if (pick == 2)
				write_window(7'd64);
			else
				write_window(CFG_W'($urandom_range(1, 16)));
			repeat (50) send_sample(random_sample());
		end
		wait_rows_drained();
	endtask

	task automatic test_terminator();
		idle_on = 1'b0;
		write_window(CFG_W'($urandom_range(1, 8)));
		repeat (20) send_sample(random_sample());
		send_sample(18'sh3FFFF);
		send_sample(18'sh20000);
		send_sample(18'sh00000);
		send_sample(18'sh1FFFF);
		send_sample(18'sh00100);
		repeat (36) send_sample(SAMPLE_W'($urandom_range(0, 262143)));
		wait_rows_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_window_sizes();
		test_random_phases();
		test_terminator();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_rows.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swmm_pkg.sv
rtl/swmm_ram.sv
rtl/swmm_core.sv
rtl/sliding_window_min_max_top.sv
bench/tb_sliding_window_min_max_top.sv
